FILE: sv/vfc_pkg.sv
// Shared types and constants of the voxel face culler.
package vfc_pkg;

    localparam int VFC_EDGE      = 16;
    localparam int VFC_TYPE_BITS = 8;

    localparam int VFC_IN_W  = 24;
    localparam int VFC_OUT_W = 32;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_READ   = 3'd2,
        ACT_SCAN   = 3'd3,
        ACT_DONE   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        DIR_PX = 3'd0,
        DIR_NX = 3'd1,
        DIR_PY = 3'd2,
        DIR_NY = 3'd3,
        DIR_PZ = 3'd4,
        DIR_NZ = 3'd5
    } t_dir;

    typedef struct packed {
        logic load_in;
        logic mem_wr;
        logic set_dirty;
        logic set_mod;
        logic clr_dirty;
        logic clr_wr;
        logic cap_center;
        logic nbr_issue;
        logic nbr_check;
        logic push_reply;
        logic push_face;
    } t_cmd;

    typedef struct packed {
        logic [2:0] act;
        logic       in_chunk;
        logic       center_zero;
        logic       dir_last;
        logic       clr_done;
        logic       mask_zero;
        logic       face_last;
        logic       out_free;
    } t_sts;

endpackage

FILE: sv/vfc_dpath.sv
// Datapath: voxel memory, flags, neighbor walk, face mask and output register.
module vfc_dpath import vfc_pkg::*; #(
    parameter int EDGE      = VFC_EDGE,
    parameter int TYPE_BITS = VFC_TYPE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [VFC_IN_W-1:0]  i_in_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [VFC_OUT_W-1:0] o_out_data,
    output logic                 o_out_kind,
    output logic                 o_out_last
);

    localparam int              VOXELS = EDGE * EDGE * EDGE;
    localparam int              AW     = $clog2(VOXELS);
    localparam logic [7:0]      EDGE_C = 8'(EDGE);

    logic [TYPE_BITS-1:0] r_mem [VOXELS];
    logic [TYPE_BITS-1:0] r_rdata;

    logic [2:0]           r_act;
    logic [3:0]           r_x, r_y, r_z;
    logic [7:0]           r_bt;
    logic [TYPE_BITS-1:0] r_type;
    logic                 r_dirty, r_mod;
    logic [AW-1:0]        r_clr;
    logic [2:0]           r_dir;
    logic                 r_chk_v;
    logic [2:0]           r_chk_dir;
    logic                 r_chk_out;
    logic [5:0]           r_mask, r_bnd;

    logic                 r_ovalid, r_okind, r_olast;
    logic [VFC_OUT_W-1:0] r_odata;

    logic [7:0]           w_cx, w_cy, w_cz, w_nx, w_ny, w_nz;
    logic                 w_nout, w_inside, w_we, w_push;
    logic [AW-1:0]        w_addr;
    logic [TYPE_BITS-1:0] w_wdata, w_ctype;
    logic [2:0]           w_sel;
    logic [5:0]           w_sel_oh;
    logic [VFC_OUT_W-1:0] n_odata;

    function automatic logic [AW-1:0] f_slot(input logic [7:0] ax, input logic [7:0] ay,
                                             input logic [7:0] az);
        return AW'(ax) * AW'(EDGE * EDGE) + AW'(ay) * AW'(EDGE) + AW'(az);
    endfunction

    assign w_cx = 8'(r_x);
    assign w_cy = 8'(r_y);
    assign w_cz = 8'(r_z);
    assign w_inside = (w_cx < EDGE_C) && (w_cy < EDGE_C) && (w_cz < EDGE_C);

    always_comb begin
        w_nx   = w_cx;
        w_ny   = w_cy;
        w_nz   = w_cz;
        w_nout = 1'b1;
        unique case (t_dir'(r_dir))
            DIR_PX: begin
                w_nx   = w_cx + 8'd1;
                w_nout = (w_cx + 8'd1) >= EDGE_C;
            end
            DIR_NX: begin
                w_nx   = w_cx - 8'd1;
                w_nout = (w_cx == 8'd0);
            end
            DIR_PY: begin
                w_ny   = w_cy + 8'd1;
                w_nout = (w_cy + 8'd1) >= EDGE_C;
            end
            DIR_NY: begin
                w_ny   = w_cy - 8'd1;
                w_nout = (w_cy == 8'd0);
            end
            DIR_PZ: begin
                w_nz   = w_cz + 8'd1;
                w_nout = (w_cz + 8'd1) >= EDGE_C;
            end
            DIR_NZ: begin
                w_nz   = w_cz - 8'd1;
                w_nout = (w_cz == 8'd0);
            end
            default: w_nout = 1'b1;
        endcase
    end

    assign w_addr  = i_cmd.clr_wr    ? r_clr :
                     i_cmd.nbr_issue ? f_slot(w_nx, w_ny, w_nz) :
                                       f_slot(w_cx, w_cy, w_cz);
    assign w_we    = i_cmd.clr_wr | i_cmd.mem_wr;
    assign w_wdata = i_cmd.clr_wr ? '0 : TYPE_BITS'(r_bt);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    assign w_ctype = w_inside ? r_rdata : '0;

    // lowest pending face first
    always_comb begin
        w_sel    = 3'd0;
        w_sel_oh = 6'd0;
        for (int i = 5; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_sel    = 3'(i);
                w_sel_oh = 6'd1 << i;
            end
        end
    end

    assign w_push = i_cmd.push_reply | i_cmd.push_face;

    always_comb begin
        if (i_cmd.push_reply) begin
            n_odata = VFC_OUT_W'({r_mod, r_dirty, (r_type != '0), 1'b0, 8'(r_type),
                                  3'(DIR_PX), r_z, r_y, r_x});
        end else begin
            n_odata = VFC_OUT_W'({r_mod, r_dirty, 1'b1, r_bnd[w_sel], 8'(r_type),
                                  w_sel, r_z, r_y, r_x});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty  <= 1'b0;
            r_mod    <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_chk_v  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.set_dirty) begin
                r_dirty <= 1'b1;
            end else if (i_cmd.clr_dirty) begin
                r_dirty <= 1'b0;
            end
            if (i_cmd.set_mod) begin
                r_mod <= 1'b1;
            end
            if (w_push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.cap_center) begin
                r_chk_v <= 1'b0;
            end else if (i_cmd.nbr_issue) begin
                r_chk_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act <= i_in_data[2:0];
            r_x   <= i_in_data[6:3];
            r_y   <= i_in_data[10:7];
            r_z   <= i_in_data[14:11];
            r_bt  <= i_in_data[22:15];
        end
        if (i_cmd.cap_center) begin
            r_type <= w_ctype;
            r_dir  <= 3'(DIR_PX);
            r_mask <= 6'd0;
            r_bnd  <= 6'd0;
        end
        if (i_cmd.nbr_issue) begin
            r_dir     <= r_dir + 3'd1;
            r_chk_dir <= r_dir;
            r_chk_out <= w_nout;
        end
        if (i_cmd.nbr_check && r_chk_v) begin
            r_mask[r_chk_dir] <= r_chk_out | (r_rdata == '0);
            r_bnd[r_chk_dir]  <= r_chk_out;
        end
        if (i_cmd.push_face) begin
            r_mask <= r_mask & ~w_sel_oh;
        end
        if (w_push) begin
            r_odata <= n_odata;
            r_okind <= i_cmd.push_reply;
            r_olast <= i_cmd.push_reply | ((r_mask & ~w_sel_oh) == 6'd0);
        end
    end

    assign o_sts.act         = r_act;
    assign o_sts.in_chunk    = w_inside;
    assign o_sts.center_zero = (w_ctype == '0);
    assign o_sts.dir_last    = (r_dir == DIR_NZ);
    assign o_sts.clr_done    = (r_clr == AW'(VOXELS - 1));
    assign o_sts.mask_zero   = (r_mask == 6'd0);
    assign o_sts.face_last   = ((r_mask & ~w_sel_oh) == 6'd0);
    assign o_sts.out_free    = ~r_ovalid | i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_kind  = r_okind;
    assign o_out_last  = r_olast;

endmodule

FILE: sv/vfc_ctrl.sv
// Controller: sequences memory clear, actions, neighbor reads and face output.
module vfc_ctrl import vfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_CWAIT  = 8'b0000_1000,
        S_REPLY  = 8'b0001_0000,
        S_SCAN   = 8'b0010_0000,
        S_SLAST  = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (t_action'(i_sts.act)) inside
                    ACT_LOAD: begin
                        o_cmd.mem_wr    = i_sts.in_chunk;
                        o_cmd.set_dirty = i_sts.in_chunk;
                    end
                    ACT_UPDATE: begin
                        o_cmd.mem_wr    = i_sts.in_chunk;
                        o_cmd.set_dirty = i_sts.in_chunk;
                        o_cmd.set_mod   = i_sts.in_chunk;
                    end
                    ACT_READ, ACT_SCAN: begin
                        n_state = S_CWAIT;
                    end
                    ACT_DONE: begin
                        o_cmd.clr_dirty = 1'b1;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CWAIT: begin
                o_cmd.cap_center = 1'b1;
                if (t_action'(i_sts.act) == ACT_READ) begin
                    n_state = S_REPLY;
                end else if (i_sts.center_zero) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.push_reply = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.nbr_issue = 1'b1;
                o_cmd.nbr_check = 1'b1;
                if (i_sts.dir_last) begin
                    n_state = S_SLAST;
                end
            end
            S_SLAST: begin
                o_cmd.nbr_check = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.mask_zero) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.push_face = 1'b1;
                    if (i_sts.face_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: sv/voxel_face_culler.sv
// Top level of the voxel face culler: controller plus datapath.
//
//  channel   dir  transaction carries
//  s_axis    in   tdata: action, pos_x, pos_y, pos_z, block_type
//  m_axis    out  tuser: kind, tlast: last, tdata: face record or read reply
//
// Load, update and mesh done finish in the decode state; read captures the center and
// then sends one reply. Scan stops after the center read on air, else it makes one
// store read per neighbor through the single memory port, then sends one output
// record per face. After reset a clear pass writes air to all EDGE^3 voxels
// with s_axis_tready low.
// m_axis stalls hold the output register; the next transaction is taken while it waits.
module voxel_face_culler import vfc_pkg::*; #(
    parameter int EDGE      = VFC_EDGE,
    parameter int TYPE_BITS = VFC_TYPE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // action[2:0], pos_x[6:3], pos_y[10:7], pos_z[14:11], block_type[22:15]
    input  logic [VFC_IN_W-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // face_x[3:0], face_y[7:4], face_z[11:8], face_dir[14:12], voxel_type[22:15],
    // on_boundary[23], is_solid[24], mesh_dirty[25], was_modified[26]
    output logic [VFC_OUT_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    vfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    vfc_dpath #(
        .EDGE      (EDGE),
        .TYPE_BITS (TYPE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

FILE: sv/vfc_checker.sv
// Port-level checker for the voxel face culler and its bind.
module vfc_checker import vfc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [VFC_IN_W-1:0]  s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [VFC_OUT_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser,
    input logic                 m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("ports active right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    a_reply_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && m_axis_tdata[14:12] == 3'(DIR_PX) && !m_axis_tdata[23])
        else $error("malformed read reply");

    a_face_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[24] && m_axis_tdata[14:12] != 3'd6 && m_axis_tdata[14:12] != 3'd7)
        else $error("malformed face record");

    a_face_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser && !m_axis_tlast |=>
            (!m_axis_tvalid ||
             (!m_axis_tuser && m_axis_tdata[11:0] == $past(m_axis_tdata[11:0]) &&
              m_axis_tdata[14:12] > $past(m_axis_tdata[14:12]))))
        else $error("face records of one scan out of order");

endmodule

bind voxel_face_culler vfc_checker u_vfc_checker (.*);
